// ===== hdl/tpft_pkg.sv =====
// Shared types and constants for the tire pressure frame tracker.
`default_nettype none

package tpft_pkg;

   localparam int unsigned NUM_POS   = 4;
   localparam int unsigned POS_W     = 2;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned PERIOD_W  = 16;
   localparam int unsigned ID_W      = 29;
   localparam int unsigned LEN_W     = 7;
   localparam int unsigned DATA_W    = 64;
   localparam int unsigned SWAP_W    = 4;

   localparam logic [ID_W-1:0]  FRAME_ID  = 29'h385;
   localparam logic [LEN_W-1:0] FRAME_LEN = 7'd8;

   typedef enum logic [1:0] {
      OP_FRAME  = 2'd0,
      OP_REPORT = 2'd1,
      OP_SWAP   = 2'd2,
      OP_TICK   = 2'd3
   } opcode_type;

   typedef logic [NUM_POS-1:0][POS_W-1:0]  pos_map_type;
   typedef logic [NUM_POS-1:0][BYTE_W-1:0] pressures_type;

   // Frame decode outcome handed back to the top level
   typedef struct packed {
      logic          hit;
      logic          changed;
      pressures_type value;
   } decode_type;

endpackage

`default_nettype wire

// ===== hdl/tpft_frame_decode.sv =====
// Per-position pressure extraction from a tire pressure CAN frame.
`default_nettype none

module tpft_frame_decode (
   input  wire logic [tpft_pkg::ID_W-1:0]   can_id,
   input  wire logic [tpft_pkg::LEN_W-1:0]  frame_length,
   input  wire logic [tpft_pkg::DATA_W-1:0] frame_data,
   input  wire tpft_pkg::pos_map_type       pos_map,
   input  wire tpft_pkg::pressures_type     stored,
   output tpft_pkg::decode_type             decode
);
   import tpft_pkg::*;

   logic [BYTE_W-1:0] flags;
   logic [2:0]        byte_idx [NUM_POS];
   logic [2:0]        flag_idx [NUM_POS];

   assign flags = frame_data[DATA_W-1 -: BYTE_W];

   always_comb begin
      decode.hit     = (can_id == FRAME_ID) && (frame_length == FRAME_LEN);
      decode.changed = 1'b0;
      decode.value   = '0;
      for (int i = 0; i < NUM_POS; i++) begin
         // tire t: data byte 2+t, valid flag in bit 7-t of byte 7
         byte_idx[i] = 3'(3'd2 + 3'(pos_map[i]));
         flag_idx[i] = 3'(3'd7 - 3'(pos_map[i]));
         if (flags[flag_idx[i]]) begin
            decode.value[i] = frame_data[{byte_idx[i], 3'b000} +: BYTE_W];
         end
         if (decode.value[i] != stored[i]) begin
            decode.changed = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tire_pressure_frame_tracker.sv =====
// Top level of the tire pressure frame tracker.
//
// Request channel (req_*): one transaction per item; opcode selects a CAN
// frame, a report request, a position swap or a one millisecond tick.
// Response channel (rsp_*): one transaction carries all four position
// pressures. Frames that change a value, report requests, valid swaps and
// expired report periods each produce one; other items produce none.
// csr_wr_en / csr_wr_data write the 16-bit report period (zero disables).
//
// An accepted item is registered in the input register and processed there once
// it may advance; a report loads the response register, which drives rsp_*.
// Throughput: one item per cycle while no response is stalled. The response
// register lets the input register take one request while a response waits.
// When rsp_stall holds a pending response, the item in the input register
// waits and req_stall rises; nothing is dropped.
// Reset (synchronous, active high) restores the identity position map, zero
// pressures, zero millisecond count and period, and empties both registers.
`default_nettype none

module tire_pressure_frame_tracker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [tpft_pkg::PERIOD_W-1:0] csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [tpft_pkg::ID_W-1:0]     req_can_id,
   input  wire logic [tpft_pkg::LEN_W-1:0]    req_frame_length,
   input  wire logic [tpft_pkg::DATA_W-1:0]   req_frame_data,
   input  wire logic [tpft_pkg::SWAP_W-1:0]   req_swap_first,
   input  wire logic [tpft_pkg::SWAP_W-1:0]   req_swap_second,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tpft_pkg::BYTE_W-1:0]        rsp_pressure_pos0,
   output logic [tpft_pkg::BYTE_W-1:0]        rsp_pressure_pos1,
   output logic [tpft_pkg::BYTE_W-1:0]        rsp_pressure_pos2,
   output logic [tpft_pkg::BYTE_W-1:0]        rsp_pressure_pos3
);
   import tpft_pkg::*;

   // input register
   logic                s1_valid_ff;
   logic                s1_valid_in;
   opcode_type          s1_opcode_ff;
   logic [ID_W-1:0]     s1_can_id_ff;
   logic [LEN_W-1:0]    s1_length_ff;
   logic [DATA_W-1:0]   s1_data_ff;
   logic [SWAP_W-1:0]   s1_first_ff;
   logic [SWAP_W-1:0]   s1_second_ff;

   // block state
   logic [PERIOD_W-1:0] period_ff;
   pos_map_type         map_ff;
   pos_map_type         map_in;
   pressures_type       pressure_ff;
   pressures_type       pressure_in;
   logic [PERIOD_W-1:0] ms_ff;
   logic [PERIOD_W-1:0] ms_in;
   logic [PERIOD_W-1:0] ms_inc;

   // response register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   pressures_type       rsp_value_ff;

   logic                advance;
   logic                accept;
   logic                report;
   logic                swap_ok;
   logic [POS_W-1:0]    pos_a;
   logic [POS_W-1:0]    pos_b;
   decode_type          decode;

   assign advance   = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   tpft_frame_decode u_decode (
      .can_id       (s1_can_id_ff),
      .frame_length (s1_length_ff),
      .frame_data   (s1_data_ff),
      .pos_map      (map_ff),
      .stored       (pressure_ff),
      .decode       (decode)
   );

   assign pos_a   = s1_first_ff[POS_W-1:0];
   assign pos_b   = s1_second_ff[POS_W-1:0];
   assign swap_ok = (s1_first_ff[SWAP_W-1:POS_W] == '0)
                 && (s1_second_ff[SWAP_W-1:POS_W] == '0)
                 && (pos_a != pos_b);
   assign ms_inc  = (ms_ff == '1) ? ms_ff : PERIOD_W'(ms_ff + 1'b1);

   always_comb begin
      map_in      = map_ff;
      pressure_in = pressure_ff;
      ms_in       = ms_ff;
      report      = 1'b0;
      if (advance) begin
         unique case (s1_opcode_ff)
            OP_FRAME: begin
               if (decode.hit) begin
                  pressure_in = decode.value;
                  report      = decode.changed;
               end
            end
            OP_REPORT: begin
               report = 1'b1;
            end
            OP_SWAP: begin
               if (swap_ok) begin
                  map_in[pos_a]      = map_ff[pos_b];
                  map_in[pos_b]      = map_ff[pos_a];
                  pressure_in[pos_a] = pressure_ff[pos_b];
                  pressure_in[pos_b] = pressure_ff[pos_a];
                  report             = 1'b1;
               end
            end
            OP_TICK: begin
               ms_in  = ms_inc;
               report = (period_ff != '0) && (ms_inc >= period_ff);
            end
            default: begin
               report = 1'b0;
            end
         endcase
         if (report) begin
            ms_in = '0;
         end
      end
   end

   assign s1_valid_in  = accept || req_stall;
   assign rsp_valid_in = report || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= '0;
         ms_ff        <= '0;
         for (int i = 0; i < NUM_POS; i++) begin
            map_ff[i] <= POS_W'(i);
         end
         pressure_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         map_ff       <= map_in;
         pressure_ff  <= pressure_in;
         ms_ff        <= ms_in;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_opcode_ff <= opcode_type'(req_opcode);
         s1_can_id_ff <= req_can_id;
         s1_length_ff <= req_frame_length;
         s1_data_ff   <= req_frame_data;
         s1_first_ff  <= req_swap_first;
         s1_second_ff <= req_swap_second;
      end
      if (report) begin
         rsp_value_ff <= pressure_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pressure_pos0 = rsp_value_ff[0];
   assign rsp_pressure_pos1 = rsp_value_ff[1];
   assign rsp_pressure_pos2 = rsp_value_ff[2];
   assign rsp_pressure_pos3 = rsp_value_ff[3];

endmodule

`default_nettype wire

// ===== hdl/tpft_checker.sv =====
// Port-level assertions for the tire pressure frame tracker, bound to the top level.
`default_nettype none

module tpft_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos0,
   input wire logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos1,
   input wire logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos2,
   input wire logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos3
);
   import tpft_pkg::*;

   // a stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid
         && $stable(rsp_pressure_pos0) && $stable(rsp_pressure_pos1)
         && $stable(rsp_pressure_pos2) && $stable(rsp_pressure_pos3))
      else $error("response changed while stalled");

   // requests back up only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // a fresh response needs a request accepted earlier
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("response without a matching request");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

endmodule

bind tire_pressure_frame_tracker tpft_checker u_tpft_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_pressure_pos0 (rsp_pressure_pos0),
   .rsp_pressure_pos1 (rsp_pressure_pos1),
   .rsp_pressure_pos2 (rsp_pressure_pos2),
   .rsp_pressure_pos3 (rsp_pressure_pos3)
);

`default_nettype wire

// ===== dv/tire_pressure_frame_tracker_checker.sv =====
// Response checker for the tire pressure frame tracker: tracks state, predicts and compares.
module tire_pressure_frame_tracker_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [tpft_pkg::PERIOD_W-1:0] csr_wr_data,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [tpft_pkg::ID_W-1:0]     req_can_id,
   input  wire logic [tpft_pkg::LEN_W-1:0]    req_frame_length,
   input  wire logic [tpft_pkg::DATA_W-1:0]   req_frame_data,
   input  wire logic [tpft_pkg::SWAP_W-1:0]   req_swap_first,
   input  wire logic [tpft_pkg::SWAP_W-1:0]   req_swap_second,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos0,
   input  wire logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos1,
   input  wire logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos2,
   input  wire logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos3,
   output int                                 fail_count,
   output int                                 pending_count
);

   tpft_pkg::pos_map_type             tire_of_pos;
   tpft_pkg::pressures_type           pressure_now;
   logic [tpft_pkg::PERIOD_W-1:0]     ms_count;
   logic [tpft_pkg::PERIOD_W-1:0]     period_ms;
   tpft_pkg::pressures_type           report_q[$];

   task automatic queue_report();
      report_q.push_back(pressure_now);
      ms_count = '0;
   endtask

   task automatic track_item(input logic [1:0]                    op_bits,
                             input logic [tpft_pkg::ID_W-1:0]     id,
                             input logic [tpft_pkg::LEN_W-1:0]    len,
                             input logic [tpft_pkg::DATA_W-1:0]   data,
                             input logic [tpft_pkg::SWAP_W-1:0]   pos_a,
                             input logic [tpft_pkg::SWAP_W-1:0]   pos_b);
      tpft_pkg::opcode_type op;
      logic [7:0]           flags;
      logic [7:0]           value;
      logic [1:0]           tmp_tire;
      logic [7:0]           tmp_pressure;
      logic                 changed;
      int                   tire;
      op = tpft_pkg::opcode_type'(op_bits);
      case (op)
         tpft_pkg::OP_FRAME: begin
            if (id == tpft_pkg::FRAME_ID && len == tpft_pkg::FRAME_LEN) begin
               flags   = data[63:56];
               changed = 1'b0;
               for (int i = 0; i < tpft_pkg::NUM_POS; i++) begin
                  tire  = int'(tire_of_pos[i]);
                  // byte 7 bit (7 - tire) flags the tire's byte (2 + tire) as valid
                  value = flags[7 - tire] ? data[8*(2 + tire) +: 8] : 8'h00;
                  if (pressure_now[i] != value) begin
                     pressure_now[i] = value;
                     changed         = 1'b1;
                  end
               end
               if (changed)
                  queue_report();
            end
         end
         tpft_pkg::OP_REPORT: queue_report();
         tpft_pkg::OP_SWAP: begin
            if (pos_a < tpft_pkg::NUM_POS && pos_b < tpft_pkg::NUM_POS && pos_a != pos_b) begin
               tmp_tire             = tire_of_pos[pos_a[1:0]];
               tire_of_pos[pos_a[1:0]] = tire_of_pos[pos_b[1:0]];
               tire_of_pos[pos_b[1:0]] = tmp_tire;
               tmp_pressure          = pressure_now[pos_a[1:0]];
               pressure_now[pos_a[1:0]] = pressure_now[pos_b[1:0]];
               pressure_now[pos_b[1:0]] = tmp_pressure;
               queue_report();
            end
         end
         default: begin
            if (ms_count != 16'hFFFF)
               ms_count = ms_count + 16'd1;
            if (period_ms != '0 && ms_count >= period_ms)
               queue_report();
         end
      endcase
   endtask

   task automatic check_report(input tpft_pkg::pressures_type got);
      tpft_pkg::pressures_type want;
      logic                    bad;
      if (report_q.size() == 0) begin
         if (fail_count < 10)
            $display("unexpected response transaction: %h", got);
         fail_count++;
      end else begin
         want = report_q.pop_front();
         bad  = 1'b0;
         for (int i = 0; i < tpft_pkg::NUM_POS; i++) begin
            if (want[i] != got[i]) begin
               if (fail_count < 10)
                  $display("pressure_pos%0d mismatch: expected %02h actual %02h",
                           i, want[i], got[i]);
               bad = 1'b1;
            end
         end
         if (bad)
            fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tpft_pkg::NUM_POS; i++)
            tire_of_pos[i] = i[1:0];
         pressure_now = '0;
         ms_count     = '0;
         period_ms    = '0;
         report_q.delete();
      end else begin
         // retire the response before predicting: a new item can't answer in the same cycle
         if (rsp_valid && !rsp_stall)
            check_report({rsp_pressure_pos3, rsp_pressure_pos2,
                          rsp_pressure_pos1, rsp_pressure_pos0});
         if (req_valid && !req_stall)
            track_item(req_opcode, req_can_id, req_frame_length, req_frame_data,
                       req_swap_first, req_swap_second);
         if (csr_wr_en)
            period_ms = csr_wr_data;
      end
      pending_count = report_q.size();
   end

endmodule

// ===== dv/tire_pressure_frame_tracker_tb.sv =====
// Testbench top for the tire pressure frame tracker: stimulus, backpressure and verdict.
module tire_pressure_frame_tracker_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 4;

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [tpft_pkg::PERIOD_W-1:0] csr_wr_data;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_opcode;
   logic [tpft_pkg::ID_W-1:0]     req_can_id;
   logic [tpft_pkg::LEN_W-1:0]    req_frame_length;
   logic [tpft_pkg::DATA_W-1:0]   req_frame_data;
   logic [tpft_pkg::SWAP_W-1:0]   req_swap_first;
   logic [tpft_pkg::SWAP_W-1:0]   req_swap_second;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos0;
   logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos1;
   logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos2;
   logic [tpft_pkg::BYTE_W-1:0]   rsp_pressure_pos3;

   int                            fail_count;
   int                            pending_count;
   int                            quiet_cycles;
   int                            stall_left;
   bit                            idle_on;
   logic [tpft_pkg::DATA_W-1:0]   last_frame;

   tire_pressure_frame_tracker i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_can_id        (req_can_id),
      .req_frame_length  (req_frame_length),
      .req_frame_data    (req_frame_data),
      .req_swap_first    (req_swap_first),
      .req_swap_second   (req_swap_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pressure_pos0 (rsp_pressure_pos0),
      .rsp_pressure_pos1 (rsp_pressure_pos1),
      .rsp_pressure_pos2 (rsp_pressure_pos2),
      .rsp_pressure_pos3 (rsp_pressure_pos3)
   );

   tire_pressure_frame_tracker_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_can_id        (req_can_id),
      .req_frame_length  (req_frame_length),
      .req_frame_data    (req_frame_data),
      .req_swap_first    (req_swap_first),
      .req_swap_second   (req_swap_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pressure_pos0 (rsp_pressure_pos0),
      .rsp_pressure_pos1 (rsp_pressure_pos1),
      .rsp_pressure_pos2 (rsp_pressure_pos2),
      .rsp_pressure_pos3 (rsp_pressure_pos3),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // response backpressure in random bursts, started only while idle_on is set
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall  = 1'b1;
            stall_left = stall_left - 1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall  = 1'b1;
            stall_left = $urandom_range(1, 6) - 1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tire_pressure_frame_tracker regression: fail");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_req(input logic [1:0]                    op,
                           input logic [tpft_pkg::ID_W-1:0]     id,
                           input logic [tpft_pkg::LEN_W-1:0]    len,
                           input logic [tpft_pkg::DATA_W-1:0]   data,
                           input logic [tpft_pkg::SWAP_W-1:0]   pos_a,
                           input logic [tpft_pkg::SWAP_W-1:0]   pos_b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_opcode       = op;
      req_can_id       = id;
      req_frame_length = len;
      req_frame_data   = data;
      req_swap_first   = pos_a;
      req_swap_second  = pos_b;
      req_valid        = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [tpft_pkg::DATA_W-1:0] data);
      send_req(tpft_pkg::OP_FRAME, tpft_pkg::FRAME_ID, tpft_pkg::FRAME_LEN, data,
               4'($urandom), 4'($urandom));
   endtask

   task automatic send_simple(input tpft_pkg::opcode_type op);
      send_req(op, 29'($urandom), 7'($urandom), {$urandom, $urandom},
               4'($urandom), 4'($urandom));
   endtask

   task automatic send_swap(input logic [3:0] pos_a, input logic [3:0] pos_b);
      send_req(tpft_pkg::OP_SWAP, 29'($urandom), 7'($urandom), {$urandom, $urandom},
               pos_a, pos_b);
   endtask

   // period writes only once the block has drained
   task automatic write_period(input logic [tpft_pkg::PERIOD_W-1:0] value);
      req_valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic random_item();
      logic [tpft_pkg::DATA_W-1:0] data;
      logic [tpft_pkg::ID_W-1:0]   id;
      logic [tpft_pkg::LEN_W-1:0]  len;
      int                          pick;
      pick = $urandom_range(0, 99);
      data = {$urandom, $urandom};
      if (pick < 40) begin
         // resend or nudge the last frame so unchanged frames show up often
         case ($urandom_range(0, 3))
            0: data = last_frame;
            1: begin
               data = last_frame;
               data[8*$urandom_range(0, 7) +: 8] = 8'($urandom);
            end
            default: ;
         endcase
         last_frame = data;
         send_frame(data);
      end else if (pick < 50) begin
         id  = $urandom_range(0, 1) ? tpft_pkg::FRAME_ID : 29'($urandom);
         len = $urandom_range(0, 1) ? tpft_pkg::FRAME_LEN : 7'($urandom_range(0, 64));
         if ($urandom_range(0, 1))
            id = tpft_pkg::FRAME_ID ^ (29'd1 << $urandom_range(0, 28));
         send_req(tpft_pkg::OP_FRAME, id, len, data, 4'($urandom), 4'($urandom));
      end else if (pick < 60) begin
         send_simple(tpft_pkg::OP_REPORT);
      end else if (pick < 75) begin
         if ($urandom_range(0, 4) == 0)
            send_swap(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         else
            send_swap(4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)));
      end else begin
         send_simple(tpft_pkg::OP_TICK);
      end
   endtask

   initial begin
      logic [tpft_pkg::PERIOD_W-1:0] phase_period[5];
      reset            = 1'b1;
      idle_on          = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_opcode       = tpft_pkg::OP_FRAME;
      req_can_id       = '0;
      req_frame_length = '0;
      req_frame_data   = '0;
      req_swap_first   = '0;
      req_swap_second  = '0;
      last_frame       = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed: decode, ignored frames, swaps, ticks with periodic reporting off
      send_simple(tpft_pkg::OP_REPORT);
      send_frame(64'hF0AA_4433_2211_BBCC);
      send_frame(64'hF0AA_4433_2211_BBCC);
      send_frame(64'h0F00_4433_2211_0000);
      send_frame(64'hFFFF_FFFF_FFFF_FFFF);
      send_frame(64'hA000_FF80_0001_0000);
      send_req(tpft_pkg::OP_FRAME, 29'h384, tpft_pkg::FRAME_LEN, 64'hF000_0000_0000_0000,
               4'd0, 4'd0);
      send_req(tpft_pkg::OP_FRAME, 29'h1FFF_FFFF, tpft_pkg::FRAME_LEN,
               64'hF000_0000_0000_0000, 4'd0, 4'd0);
      send_req(tpft_pkg::OP_FRAME, tpft_pkg::FRAME_ID, 7'd0, 64'hF012_3456_789A_0000,
               4'd15, 4'd15);
      send_req(tpft_pkg::OP_FRAME, tpft_pkg::FRAME_ID, 7'd64, 64'hF012_3456_789A_0000,
               4'd15, 4'd15);
      send_req(tpft_pkg::OP_FRAME, tpft_pkg::FRAME_ID, 7'd7, 64'hF012_3456_789A_0000,
               4'd0, 4'd0);
      send_req(tpft_pkg::OP_FRAME, tpft_pkg::FRAME_ID, 7'd9, 64'hF012_3456_789A_0000,
               4'd0, 4'd0);
      send_swap(4'd0, 4'd3);
      send_swap(4'd1, 4'd2);
      send_swap(4'd4, 4'd0);
      send_swap(4'd2, 4'd2);
      send_swap(4'd15, 4'd15);
      send_swap(4'd3, 4'd15);
      send_frame(64'hF0FF_4433_2211_0000);
      send_frame(64'h5000_4433_2211_0000);
      send_swap(4'd3, 4'd0);
      repeat (3) send_simple(tpft_pkg::OP_TICK);
      send_simple(tpft_pkg::OP_REPORT);

      write_period(16'd2);
      repeat (5) send_simple(tpft_pkg::OP_TICK);

      phase_period[0] = 16'd1;
      phase_period[1] = 16'($urandom_range(2, 12));
      phase_period[2] = 16'd0;
      phase_period[3] = 16'hFFFF;
      phase_period[4] = 16'($urandom_range(1, 40));
      for (int p = 0; p < 5; p++) begin
         write_period(phase_period[p]);
         for (int n = 0; n < 105; n++) begin
            if (p == 4)
               idle_on = 1'b0;
            else if (n % 30 == 0)
               idle_on = ($urandom_range(0, 2) != 0);
            random_item();
         end
      end
      req_valid = 1'b0;

      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tire_pressure_frame_tracker regression: pass");
      else
         $display("tire_pressure_frame_tracker regression: fail");
      $finish;
   end

endmodule
